// File: rtl/gicc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gicc_pkg
// Shared types and constants of the grid index / coordinate converter.
// ----------------------------------------------------------------------------
package gicc_pkg;

	localparam int MAX_NODES_DEFAULT = 1024;

	localparam int IDX_W   = 30;
	localparam int NODE_W  = 10;
	localparam int CART_W  = 29;
	localparam int STEP_W  = 24;
	localparam int ORG_W   = 28;
	localparam int DIM_W   = 11;
	localparam int SQ_W    = 18;
	localparam int SR_W    = 7;

	localparam logic [IDX_W-1:0] INDEX_MAX = 30'h3FFF_FFFF;

	// Operation codes
	localparam logic OP_SPLIT = 1'b0;
	localparam logic OP_JOIN  = 1'b1;

	// Register indexes
	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_STEP_X      = 3'd2;
	localparam logic [2:0] REG_STEP_Y      = 3'd3;
	localparam logic [2:0] REG_STEP_Z      = 3'd4;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd5;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd6;
	localparam logic [2:0] REG_ORIGIN_Z    = 3'd7;

	// floor(n/100) = (n * RECIP) >> SHIFT, exact over the stated operand range
	localparam logic [24:0] RECIP_STEP = 25'd21474837; // n < 2^24
	localparam int          SHIFT_STEP = 31;
	localparam logic [17:0] RECIP_REM  = 18'd167773;   // n < 2^17
	localparam int          SHIFT_REM  = 24;

	localparam logic [SQ_W-1:0] SQ_RESET = 18'd10000;

	typedef struct packed {
		logic [SQ_W-1:0]         sq;     // step / 100
		logic [SR_W-1:0]         sr;     // step % 100
		logic signed [ORG_W-1:0] origin;
	} coord_cfg_t;

endpackage

`default_nettype wire

// File: rtl/gicc_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gicc_div_cell
// One restoring divide step: decides one quotient bit and passes on.
// ----------------------------------------------------------------------------
module gicc_div_cell #(
	parameter int RW  = 30,
	parameter int DW  = 21,
	parameter int QW  = 30,
	parameter int BIT = 0,
	parameter int PW  = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [RW-1:0] in_rem,
	input  wire logic [QW-1:0] in_quot,
	input  wire logic [PW-1:0] in_pay,
	input  wire logic [DW-1:0] divisor,
	output logic               out_valid,
	output logic [RW-1:0]      out_rem,
	output logic [QW-1:0]      out_quot,
	output logic [PW-1:0]      out_pay
);
	localparam int CW = RW + DW;

	logic [CW-1:0] shifted;
	logic [CW-1:0] diff;
	logic          ge;
	logic [RW-1:0] rem_nx;
	logic [QW-1:0] quot_nx;

	always_comb begin
		shifted = CW'(divisor) << BIT;
		ge      = CW'(in_rem) >= shifted;
		diff    = CW'(in_rem) - shifted;
		rem_nx  = ge ? diff[RW-1:0] : in_rem;
		quot_nx = in_quot;
		quot_nx[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= rem_nx;
			out_quot <= quot_nx;
			out_pay  <= in_pay;
		end
	end

endmodule

`default_nettype wire

// File: rtl/gicc_coord_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gicc_coord_unit
// node * step rounded half to even to 1e-4 A, plus origin, saturated.
// ----------------------------------------------------------------------------
module gicc_coord_unit (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [gicc_pkg::NODE_W-1:0]   node,
	input  wire gicc_pkg::coord_cfg_t          cfg,
	output logic signed [gicc_pkg::CART_W-1:0] cart
);
	import gicc_pkg::*;

	localparam int A_W = NODE_W + SQ_W;
	localparam int B_W = 17;
	localparam int P_W = B_W + SQ_W;
	localparam int S_W = 31;

	logic [A_W-1:0] a_s1, a_s2;
	logic [B_W-1:0] b_s1, b_s2;
	logic [9:0]     bq_s2;
	logic [A_W:0]   q_s3;
	logic [SR_W-1:0] br_s3;

	logic [P_W-1:0] bprod;
	logic [B_W-1:0] bsub;
	logic           rnd;
	logic signed [S_W-1:0] sum;

	always_comb begin
		bprod = P_W'(b_s1) * P_W'(RECIP_REM);
		bsub  = b_s2 - B_W'(bq_s2) * B_W'(100);
		rnd   = (br_s3 > SR_W'(50)) || ((br_s3 == SR_W'(50)) && q_s3[0]);
		sum   = $signed(S_W'(q_s3)) + $signed(S_W'(rnd)) + S_W'(cfg.origin);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= A_W'(node) * A_W'(cfg.sq);
			b_s1  <= B_W'(node) * B_W'(cfg.sr);
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			bq_s2 <= bprod[SHIFT_REM +: 10];
			q_s3  <= (A_W+1)'(a_s2) + (A_W+1)'(bq_s2);
			br_s3 <= bsub[SR_W-1:0];
			// clamp to the signed coordinate range
			if (sum > S_W'(268435455)) begin
				cart <= CART_W'(268435455);
			end else if (sum < -S_W'(268435456)) begin
				cart <= CART_W'(-S_W'(268435456));
			end else begin
				cart <= sum[CART_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/grid_index_coordinate_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_index_coordinate_converter
// Linear grid index to node indices and coordinates, and back.
// ----------------------------------------------------------------------------
// Path: front stages, then divide cells (30 for the plane split, clog2(MAX)
// for the row split), then coordinate stages and the output register.
// Throughput: one request per cycle; the whole chain stalls while a result waits.
// Config-derived terms are registered: wd_q/hd_q then plane_q, sq_q then sr_q.
// Reset clears all valid bits and restores the register reset values.
// ----------------------------------------------------------------------------
module grid_index_coordinate_converter #(
	parameter int MAX_NODES_PER_AXIS = gicc_pkg::MAX_NODES_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// in_linear_index[29:0], in_node_x[39:30], in_node_y[49:40], in_node_z[59:50]
	input  wire logic [63:0]  s_axis_tdata,
	// operation[0]
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_node_x[9:0], out_node_y[19:10], out_node_z[29:20], out_cart_x[58:30],
	// out_cart_y[87:59], out_cart_z[116:88], out_linear_index[146:117],
	// z_overflow[147]
	output logic [151:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [27:0]  cfg_data
);
	import gicc_pkg::*;

	localparam int DW    = $clog2(MAX_NODES_PER_AXIS + 1);
	localparam int NW    = $clog2(MAX_NODES_PER_AXIS);
	localparam int PLW   = 2 * DW;
	localparam int LIMIT = (MAX_NODES_PER_AXIS - 1 > 1023) ? 1023 : MAX_NODES_PER_AXIS - 1;
	localparam int MZW   = NODE_W + PLW;
	localparam int MYW   = NODE_W + DW;
	localparam int LSW   = MZW + 1;
	localparam int P1W   = 1 + IDX_W;
	localparam int P2W   = P1W + 1 + NODE_W;
	localparam int CPW   = P1W + 1 + 3 * NODE_W;
	localparam int SPW   = STEP_W + 25;

	// ---------------- configuration ----------------
	logic [DIM_W-1:0]        grid_width_q, grid_height_q;
	logic [STEP_W-1:0]       step_q [0:2];
	logic signed [ORG_W-1:0] origin_q [0:2];
	logic [DW-1:0]           wd_q, hd_q;
	logic [PLW-1:0]          plane_q;
	logic [SQ_W-1:0]         sq_q [0:2];
	logic [SR_W-1:0]         sr_q [0:2];
	coord_cfg_t              ccfg [0:2];

	function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DW-1:0] d;
		if (v == '0) begin
			d = DW'(1);
		end else if (int'(v) > MAX_NODES_PER_AXIS) begin
			d = DW'(MAX_NODES_PER_AXIS);
		end else begin
			d = DW'(v);
		end
		return d;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_W'(1);
			grid_height_q <= DIM_W'(1);
			step_q[0]     <= STEP_W'(1000000);
			step_q[1]     <= STEP_W'(1000000);
			step_q[2]     <= STEP_W'(1000000);
			origin_q[0]   <= '0;
			origin_q[1]   <= '0;
			origin_q[2]   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
				REG_STEP_X:      step_q[0]     <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:      step_q[1]     <= cfg_data[STEP_W-1:0];
				REG_STEP_Z:      step_q[2]     <= cfg_data[STEP_W-1:0];
				REG_ORIGIN_X:    origin_q[0]   <= $signed(cfg_data);
				REG_ORIGIN_Y:    origin_q[1]   <= $signed(cfg_data);
				REG_ORIGIN_Z:    origin_q[2]   <= $signed(cfg_data);
			endcase
		end
	end

	logic [SPW-1:0] sprod [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q    <= DW'(1);
			hd_q    <= DW'(1);
			plane_q <= PLW'(1);
			for (int i = 0; i < 3; i++) begin
				sq_q[i] <= SQ_RESET;
				sr_q[i] <= '0;
			end
		end else begin
			wd_q    <= eff_dim(grid_width_q);
			hd_q    <= eff_dim(grid_height_q);
			plane_q <= PLW'(wd_q) * PLW'(hd_q);
			for (int i = 0; i < 3; i++) begin
				sq_q[i] <= sprod[i][SHIFT_STEP +: SQ_W];
				sr_q[i] <= SR_W'(step_q[i] - STEP_W'(sq_q[i]) * STEP_W'(100));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sprod[i]       = SPW'(step_q[i]) * SPW'(RECIP_STEP);
			ccfg[i].sq     = sq_q[i];
			ccfg[i].sr     = sr_q[i];
			ccfg[i].origin = origin_q[i];
		end
	end

	// ---------------- front stages ----------------
	logic adv;
	logic out_v_q;

	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;

	logic              v_s1, v_s2, v_s3;
	logic              op_s1, op_s2, op_s3;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3;
	logic [NODE_W-1:0] nx_s1, ny_s1, nz_s1, nx_s2;
	logic [MZW-1:0]    mz_s2;
	logic [MYW-1:0]    my_s2;
	logic [IDX_W-1:0]  lin_s3;
	logic [LSW-1:0]    lsum;

	assign lsum = LSW'(mz_s2) + LSW'(my_s2) + LSW'(nx_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= s_axis_tuser[0];
			idx_s1 <= s_axis_tdata[29:0];
			nx_s1  <= s_axis_tdata[39:30];
			ny_s1  <= s_axis_tdata[49:40];
			nz_s1  <= s_axis_tdata[59:50];
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			nx_s2  <= nx_s1;
			mz_s2  <= MZW'(nz_s1) * MZW'(plane_q);
			my_s2  <= MYW'(ny_s1) * MYW'(wd_q);
			op_s3  <= op_s2;
			idx_s3 <= idx_s2;
			// saturate the rebuilt index
			lin_s3 <= (64'(lsum) > 64'(INDEX_MAX)) ? INDEX_MAX : IDX_W'(lsum);
		end
	end

	// ---------------- plane split: idx / plane ----------------
	logic             d1_v   [0:IDX_W];
	logic [IDX_W-1:0] d1_rem [0:IDX_W];
	logic [IDX_W-1:0] d1_q   [0:IDX_W];
	logic [P1W-1:0]   d1_pay [0:IDX_W];

	assign d1_v[0]   = v_s3;
	assign d1_rem[0] = idx_s3;
	assign d1_q[0]   = '0;
	assign d1_pay[0] = {op_s3, lin_s3};

	for (genvar i = 0; i < IDX_W; i++) begin : g_div1
		gicc_div_cell #(
			.RW(IDX_W), .DW(PLW), .QW(IDX_W), .BIT(IDX_W - 1 - i), .PW(P1W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_valid(d1_v[i]), .in_rem(d1_rem[i]), .in_quot(d1_q[i]),
			.in_pay(d1_pay[i]), .divisor(plane_q),
			.out_valid(d1_v[i+1]), .out_rem(d1_rem[i+1]), .out_quot(d1_q[i+1]),
			.out_pay(d1_pay[i+1])
		);
	end

	logic              zovf;
	logic [NODE_W-1:0] zs;

	assign zovf = d1_q[IDX_W] > IDX_W'(LIMIT);
	assign zs   = zovf ? NODE_W'(LIMIT) : d1_q[IDX_W][NODE_W-1:0];

	// ---------------- row split: rem / width ----------------
	logic           d2_v   [0:NW];
	logic [PLW-1:0] d2_rem [0:NW];
	logic [NW-1:0]  d2_q   [0:NW];
	logic [P2W-1:0] d2_pay [0:NW];

	assign d2_v[0]   = d1_v[IDX_W];
	assign d2_rem[0] = d1_rem[IDX_W][PLW-1:0];
	assign d2_q[0]   = '0;
	assign d2_pay[0] = {d1_pay[IDX_W], zovf, zs};

	for (genvar i = 0; i < NW; i++) begin : g_div2
		gicc_div_cell #(
			.RW(PLW), .DW(DW), .QW(NW), .BIT(NW - 1 - i), .PW(P2W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_valid(d2_v[i]), .in_rem(d2_rem[i]), .in_quot(d2_q[i]),
			.in_pay(d2_pay[i]), .divisor(wd_q),
			.out_valid(d2_v[i+1]), .out_rem(d2_rem[i+1]), .out_quot(d2_q[i+1]),
			.out_pay(d2_pay[i+1])
		);
	end

	logic [NODE_W-1:0] xs, ys;
	logic [DW-1:0]     xq;

	assign xq = d2_rem[NW][DW-1:0];
	assign ys = (32'(d2_q[NW]) > 32'(LIMIT)) ? NODE_W'(LIMIT) : NODE_W'(d2_q[NW]);
	assign xs = (32'(xq) > 32'(LIMIT)) ? NODE_W'(LIMIT) : NODE_W'(xq);

	// ---------------- coordinates ----------------
	logic signed [CART_W-1:0] cart [0:2];
	logic [NODE_W-1:0]        cnode [0:2];
	logic [NODE_W-1:0]        zs_d;

	assign zs_d = d2_pay[NW][NODE_W-1:0];

	assign cnode[0] = xs;
	assign cnode[1] = ys;
	assign cnode[2] = zs_d;

	for (genvar a = 0; a < 3; a++) begin : g_coord
		gicc_coord_unit u_coord (
			.clk(clk), .en(adv), .node(cnode[a]), .cfg(ccfg[a]), .cart(cart[a])
		);
	end

	logic           cv_q [0:3];
	logic [CPW-1:0] cp_q [0:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cv_q[i] <= 1'b0;
			end
		end else if (adv) begin
			cv_q[0] <= d2_v[NW];
			for (int i = 1; i < 4; i++) begin
				cv_q[i] <= cv_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// op, lin, zovf, x, y, z
			cp_q[0] <= {d2_pay[NW][P2W-1:NODE_W], xs, ys, zs_d};
			for (int i = 1; i < 4; i++) begin
				cp_q[i] <= cp_q[i-1];
			end
		end
	end

	// ---------------- output register ----------------
	logic                     op_o;
	logic [IDX_W-1:0]         lin_o;
	logic                     ovf_o;
	logic [NODE_W-1:0]        x_o, y_o, z_o;
	logic [NODE_W-1:0]        nx_q, ny_q, nz_q;
	logic signed [CART_W-1:0] cx_q, cy_q, cz_q;
	logic [IDX_W-1:0]         lin_q;
	logic                     ovf_q;

	assign {op_o, lin_o, ovf_o, x_o, y_o, z_o} = cp_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= cv_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_o == OP_JOIN) begin
				nx_q  <= '0;
				ny_q  <= '0;
				nz_q  <= '0;
				cx_q  <= '0;
				cy_q  <= '0;
				cz_q  <= '0;
				ovf_q <= 1'b0;
				lin_q <= lin_o;
			end else begin
				nx_q  <= x_o;
				ny_q  <= y_o;
				nz_q  <= z_o;
				cx_q  <= cart[0];
				cy_q  <= cart[1];
				cz_q  <= cart[2];
				ovf_q <= ovf_o;
				lin_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'b0, ovf_q, lin_q, cz_q, cy_q, cx_q, nz_q, ny_q, nx_q};

`ifndef SYNTHESIS
	a_join_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && lin_q != '0 |-> nx_q == '0 && nz_q == '0 && !ovf_q && cx_q == '0)
		else $error("rebuilt index carries split fields");
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ovf_q |-> nz_q == NODE_W'(LIMIT))
		else $error("z overflow without saturated z node");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !m_axis_tready |-> !m_axis_tvalid)
		else $error("input taken while a result is stalled");
`endif

endmodule

`default_nettype wire
